// File: hdl/vle_pkg.sv
package vle_pkg;

    localparam int NUM_ROWS   = 16;
    localparam int NUM_LAYERS = 4;
    localparam int NUM_COLS   = 16;

    localparam int STORE_DEPTH = NUM_ROWS * NUM_LAYERS * NUM_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int VALUE_W     = 10;
    localparam int ROW_W       = 4;
    localparam int LAYER_W     = 2;
    localparam int COL_W       = 4;

    localparam int NEIGHBOURS = 26;
    localparam int CNT_W      = $clog2(NEIGHBOURS + 1);
    localparam int OFS_W      = 2;
    localparam logic [OFS_W-1:0] OFS_LAST = OFS_W'(2);

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TEST  = 1'b1;
    localparam logic PEAK_MAX   = 1'b1;
    localparam logic PEAK_MIN   = 1'b0;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [OFS_W-1:0]   ofs_t;

    typedef struct packed {
        logic                 kind;
        logic [ROW_W-1:0]     row;
        logic [LAYER_W-1:0]   layer;
        logic [COL_W-1:0]     col;
        logic [VALUE_W-1:0]   value;
    } cmd_word_t;

    typedef struct packed {
        logic                 is_peak;
        logic                 peak_kind;
        logic [VALUE_W-1:0]   centre_value;
    } result_word_t;

    function automatic addr_t voxel_addr(
        input logic [ROW_W:0]   r,
        input logic [LAYER_W:0] l,
        input logic [COL_W:0]   c
    );
        int lin;
        lin = (int'(r) * NUM_LAYERS + int'(l)) * NUM_COLS + int'(c);
        return ADDR_W'(lin);
    endfunction

endpackage

// File: hdl/voxel_local_extremum_3d.sv
// A write word, or any word outside the volume, returns its result in the next cycle with
// busy low; only a write inside the volume stores its voxel. A test word keeps busy high
// until done; in the interior it reads the centre, then all 27 positions of its 3x3x3 cube,
// one per cycle through the single port of the voxel memory, at an edge only the centre.
// Each result appears for one cycle with done high and must be taken in that cycle.
module voxel_local_extremum_3d
    import vle_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  cmd_word_t    cmd,
    output logic         busy,
    output logic         done,
    output result_word_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_SCAN,
        ST_TAIL,
        ST_EDGE
    } state_t;

    state_t             state_reg,   state_next;
    logic [ROW_W-1:0]   row_reg,     row_next;
    logic [LAYER_W-1:0] layer_reg,   layer_next;
    logic [COL_W-1:0]   col_reg,     col_next;
    ofs_t               da_reg,      da_next;
    ofs_t               db_reg,      db_next;
    ofs_t               dc_reg,      dc_next;
    value_t             centre_reg,  centre_next;
    cnt_t               smaller_reg, smaller_next;
    cnt_t               larger_reg,  larger_next;
    logic               done_reg,    done_next;
    result_word_t       result_reg,  result_next;

    logic               accept;
    logic               in_vol;
    logic               interior;
    logic               ram_we;
    addr_t              ram_addr;
    value_t             ram_rdata;
    logic [ROW_W:0]     nrow;
    logic [LAYER_W:0]   nlayer;
    logic [COL_W:0]     ncol;
    logic               cmp_lt;
    logic               cmp_gt;
    cnt_t               smaller_sum;
    cnt_t               larger_sum;

    assign accept = start && !busy;
    assign in_vol = (int'(cmd.row) < NUM_ROWS) && (int'(cmd.layer) < NUM_LAYERS)
                 && (int'(cmd.col) < NUM_COLS);

    assign interior = (row_reg != '0) && (int'(row_reg) <= NUM_ROWS - 2)
                   && (layer_reg != '0) && (int'(layer_reg) <= NUM_LAYERS - 2)
                   && (col_reg != '0) && (int'(col_reg) <= NUM_COLS - 2);

    assign nrow   = {1'b0, row_reg} + (ROW_W + 1)'(da_reg) - (ROW_W + 1)'(1);
    assign nlayer = {1'b0, layer_reg} + (LAYER_W + 1)'(db_reg) - (LAYER_W + 1)'(1);
    assign ncol   = {1'b0, col_reg} + (COL_W + 1)'(dc_reg) - (COL_W + 1)'(1);

    assign ram_we = accept && (cmd.kind == KIND_WRITE) && in_vol;

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:   ram_addr = voxel_addr({1'b0, cmd.row}, {1'b0, cmd.layer},
                                             {1'b0, cmd.col});
            ST_SCAN:   ram_addr = voxel_addr(nrow, nlayer, ncol);
            default:   ram_addr = voxel_addr({1'b0, row_reg}, {1'b0, layer_reg},
                                             {1'b0, col_reg});
        endcase
    end

    vle_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (cmd.value),
        .rdata (ram_rdata)
    );

    assign cmp_lt      = ram_rdata < centre_reg;
    assign cmp_gt      = ram_rdata > centre_reg;
    assign smaller_sum = smaller_reg + CNT_W'(cmp_lt);
    assign larger_sum  = larger_reg + CNT_W'(cmp_gt);

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        layer_next   = layer_reg;
        col_next     = col_reg;
        da_next      = da_reg;
        db_next      = db_reg;
        dc_next      = dc_reg;
        centre_next  = centre_reg;
        smaller_next = smaller_reg;
        larger_next  = larger_reg;
        done_next    = 1'b0;
        result_next  = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    row_next   = cmd.row;
                    layer_next = cmd.layer;
                    col_next   = cmd.col;
                    result_next.is_peak      = 1'b0;
                    result_next.peak_kind    = PEAK_MIN;
                    result_next.centre_value = '0;
                    if (!in_vol)
                    begin
                        done_next = 1'b1;
                    end
                    else if (cmd.kind == KIND_WRITE)
                    begin
                        done_next = 1'b1;
                        result_next.centre_value = cmd.value;
                    end
                    else
                    begin
                        state_next = ST_CENTRE;
                    end
                end
            end
            ST_CENTRE:
            begin
                da_next      = '0;
                db_next      = '0;
                dc_next      = '0;
                smaller_next = '0;
                larger_next  = '0;
                state_next   = interior ? ST_SCAN : ST_EDGE;
            end
            ST_SCAN:
            begin
                if ((da_reg == '0) && (db_reg == '0) && (dc_reg == '0))
                begin
                    centre_next = ram_rdata;
                end
                else
                begin
                    smaller_next = smaller_sum;
                    larger_next  = larger_sum;
                end
                if (dc_reg != OFS_LAST)
                begin
                    dc_next = dc_reg + ofs_t'(1);
                end
                else
                begin
                    dc_next = '0;
                    if (db_reg != OFS_LAST)
                    begin
                        db_next = db_reg + ofs_t'(1);
                    end
                    else
                    begin
                        db_next = '0;
                        if (da_reg != OFS_LAST)
                        begin
                            da_next = da_reg + ofs_t'(1);
                        end
                        else
                        begin
                            state_next = ST_TAIL;
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                done_next = 1'b1;
                result_next.centre_value = centre_reg;
                if (int'(smaller_sum) == NEIGHBOURS)
                begin
                    result_next.is_peak   = 1'b1;
                    result_next.peak_kind = PEAK_MAX;
                end
                else if (int'(larger_sum) == NEIGHBOURS)
                begin
                    result_next.is_peak   = 1'b1;
                    result_next.peak_kind = PEAK_MIN;
                end
                state_next = ST_IDLE;
            end
            ST_EDGE:
            begin
                done_next = 1'b1;
                result_next.centre_value = ram_rdata;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            layer_reg   <= '0;
            col_reg     <= '0;
            da_reg      <= '0;
            db_reg      <= '0;
            dc_reg      <= '0;
            centre_reg  <= '0;
            smaller_reg <= '0;
            larger_reg  <= '0;
            done_reg    <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            layer_reg   <= layer_next;
            col_reg     <= col_next;
            da_reg      <= da_next;
            db_reg      <= db_next;
            dc_reg      <= dc_next;
            centre_reg  <= centre_next;
            smaller_reg <= smaller_next;
            larger_reg  <= larger_next;
            done_reg    <= done_next;
            result_reg  <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hdl/vle_ram.sv
module vle_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sim/testbench.sv
module testbench;
    import vle_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int TOTAL_WORDS = 1150;
    localparam int CALM_WORDS  = 150;

    typedef struct packed {
        cmd_word_t  word;
        logic [3:0] gap;
        logic       drain;
    } queued_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    cmd_word_t    cmd = '0;
    logic         busy;
    logic         done;
    result_word_t result;

    queued_word_t pending_words[$];
    result_word_t expected_results[$];
    value_t       voxel_mirror[STORE_DEPTH];
    bit           voxel_written[STORE_DEPTH];

    int           words_accepted = 0;
    int           results_seen = 0;
    int           mismatches = 0;
    int           quiet_cycles = 0;
    bit           stalled = 1'b0;
    bit           idle_on = 1'b1;
    bit           drain_next = 1'b0;
    queued_word_t staged_word = '0;
    bit           staged = 1'b0;
    int           hold_cycles = 0;

    voxel_local_extremum_3d u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic int vox_index(int r, int l, int c);
        return (r * NUM_LAYERS + l) * NUM_COLS + c;
    endfunction

    function automatic bit in_volume(int r, int l, int c);
        return r >= 0 && r < NUM_ROWS && l >= 0 && l < NUM_LAYERS && c >= 0 && c < NUM_COLS;
    endfunction

    // Applies one word to the mirrored volume and returns the result word it must produce.
    function automatic result_word_t apply_word(cmd_word_t w);
        result_word_t res;
        value_t       centre;
        value_t       v;
        int           r;
        int           l;
        int           c;
        int           below;
        int           above;
        res = '0;
        r = int'(w.row);
        l = int'(w.layer);
        c = int'(w.col);
        below = 0;
        above = 0;
        if (w.kind == KIND_WRITE)
        begin
            voxel_mirror[vox_index(r, l, c)] = w.value;
            res.centre_value = w.value;
        end
        else
        begin
            centre = voxel_mirror[vox_index(r, l, c)];
            for (int dr = -1; dr <= 1; dr++)
            begin
                for (int dl = -1; dl <= 1; dl++)
                begin
                    for (int dc = -1; dc <= 1; dc++)
                    begin
                        if (in_volume(r + dr, l + dl, c + dc))
                        begin
                            v = voxel_mirror[vox_index(r + dr, l + dl, c + dc)];
                            if (v < centre)
                                below++;
                            else if (v > centre)
                                above++;
                        end
                    end
                end
            end
            if (below == NEIGHBOURS)
            begin
                res.is_peak = 1'b1;
                res.peak_kind = PEAK_MAX;
            end
            else if (above == NEIGHBOURS)
            begin
                res.is_peak = 1'b1;
                res.peak_kind = PEAK_MIN;
            end
            res.centre_value = centre;
        end
        return res;
    endfunction

    // A test must never read a voxel that was not written: a boundary test reads only
    // the centre, an interior test reads the whole cube.
    function automatic bit testable(int r, int l, int c);
        if (!voxel_written[vox_index(r, l, c)])
            return 1'b0;
        if (r == 0 || r == NUM_ROWS - 1 || l == 0 || l == NUM_LAYERS - 1 ||
            c == 0 || c == NUM_COLS - 1)
            return 1'b1;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dl = -1; dl <= 1; dl++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    if (!voxel_written[vox_index(r + dr, l + dl, c + dc)])
                        return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic queue_word(logic kind, int r, int l, int c, int v);
        queued_word_t q;
        q.word.kind = kind;
        q.word.row = r[ROW_W-1:0];
        q.word.layer = l[LAYER_W-1:0];
        q.word.col = c[COL_W-1:0];
        q.word.value = v[VALUE_W-1:0];
        q.gap = (idle_on && $urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 14)) : 4'd0;
        q.drain = drain_next;
        drain_next = 1'b0;
        if (kind == KIND_WRITE)
            voxel_written[vox_index(r, l, c)] = 1'b1;
        pending_words.push_back(q);
    endtask

    task automatic fill_cube(int r, int l, int c, int v);
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dl = -1; dl <= 1; dl++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    queue_word(KIND_WRITE, r + dr, l + dl, c + dc, v);
                end
            end
        end
    endtask

    // Shapes: 0 maximum, 1 minimum, 2 maximum spoiled by a tie, 3 minimum spoiled by a tie,
    // 4 maximum spoiled by one higher neighbor (a tie if the centre is 1023), 5 random contents.
    task automatic build_cube(int r, int l, int c, int shape);
        int centre;
        int v;
        int k;
        int spoil;
        case (shape)
            0, 2, 4: centre = ($urandom_range(0, 3) == 0) ? 1023 : $urandom_range(1, 1023);
            1, 3:    centre = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 1022);
            default: centre = $urandom_range(0, 1023);
        endcase
        spoil = $urandom_range(0, 25);
        k = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dl = -1; dl <= 1; dl++)
            begin
                for (int dc = -1; dc <= 1; dc++)
                begin
                    if (dr != 0 || dl != 0 || dc != 0)
                    begin
                        case (shape)
                            0, 2, 4: v = $urandom_range(0, 1) ? centre - 1 :
                                         $urandom_range(0, centre - 1);
                            1, 3:    v = $urandom_range(0, 1) ? centre + 1 :
                                         $urandom_range(centre + 1, 1023);
                            default: v = $urandom_range(0, 1023);
                        endcase
                        if (k == spoil && (shape == 2 || shape == 3))
                            v = centre;
                        if (k == spoil && shape == 4)
                            v = (centre == 1023) ? centre : $urandom_range(centre + 1, 1023);
                        queue_word(KIND_WRITE, r + dr, l + dl, c + dc, v);
                        k++;
                    end
                end
            end
        end
        queue_word(KIND_WRITE, r, l, c, centre);
        queue_word(KIND_TEST, r, l, c, $urandom_range(0, 1023));
        if ($urandom_range(0, 2) == 0)
        begin
            queue_word(KIND_WRITE, r + int'($urandom_range(0, 2)) - 1,
                       l + int'($urandom_range(0, 2)) - 1,
                       c + int'($urandom_range(0, 2)) - 1, $urandom_range(0, 1023));
            queue_word(KIND_TEST, r, l, c, $urandom_range(0, 1023));
        end
    endtask

    task automatic test_random_spot();
        int r;
        int l;
        int c;
        bit found;
        found = 1'b0;
        for (int tries = 0; tries < 40 && !found; tries++)
        begin
            r = $urandom_range(0, NUM_ROWS - 1);
            l = $urandom_range(0, NUM_LAYERS - 1);
            c = $urandom_range(0, NUM_COLS - 1);
            found = testable(r, l, c);
        end
        if (found)
            queue_word(KIND_TEST, r, l, c, $urandom_range(0, 1023));
        else
            queue_word(KIND_WRITE, r, l, c, $urandom_range(0, 1023));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        queued_word_t nxt;
        int           outstanding;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
            staged <= 1'b0;
            hold_cycles <= 0;
        end
        else
        begin
            outstanding = words_accepted - results_seen;
            if (start && !busy)
            begin
                expected_results.push_back(apply_word(cmd));
                words_accepted <= words_accepted + 1;
                outstanding = outstanding + 1;
            end
            if (!start || !busy)
            begin
                if (hold_cycles != 0)
                begin
                    start <= 1'b0;
                    hold_cycles <= hold_cycles - 1;
                end
                else if (staged)
                begin
                    if (staged_word.drain && outstanding != 0)
                        start <= 1'b0;
                    else
                    begin
                        start <= 1'b1;
                        cmd <= staged_word.word;
                        staged <= 1'b0;
                    end
                end
                else if (pending_words.size() != 0)
                begin
                    nxt = pending_words.pop_front();
                    if (nxt.gap == 0 && !(nxt.drain && outstanding != 0))
                    begin
                        start <= 1'b1;
                        cmd <= nxt.word;
                    end
                    else
                    begin
                        staged_word <= nxt;
                        staged <= 1'b1;
                        hold_cycles <= (nxt.gap == 0) ? 0 : int'(nxt.gap) - 1;
                        start <= 1'b0;
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        result_word_t want;
        if (rst_n && done)
        begin
            if (results_seen >= words_accepted)
            begin
                if (mismatches < 10)
                    $display("unexpected result word: peak=%0b kind=%0b value=%0d",
                             result.is_peak, result.peak_kind, result.centre_value);
                mismatches <= mismatches + 1;
            end
            else
            begin
                want = expected_results[results_seen];
                results_seen <= results_seen + 1;
                if (result.is_peak !== want.is_peak || result.peak_kind !== want.peak_kind ||
                    result.centre_value !== want.centre_value)
                begin
                    if (mismatches < 10)
                        $display("result %0d: want %0b/%0b/%0d, got %0b/%0b/%0d",
                                 results_seen, want.is_peak, want.peak_kind, want.centre_value,
                                 result.is_peak, result.peak_kind, result.centre_value);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
            stalled <= 1'b1;
    end

    initial
    begin : stimulus
        int pick;
        foreach (voxel_mirror[i])
        begin
            voxel_mirror[i] = '0;
            voxel_written[i] = 1'b0;
        end

        // A flat cube, then the centre raised, lowered, and tied with one neighbor; then two corners.
        idle_on = 1'b1;
        fill_cube(NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 512);
        queue_word(KIND_TEST, NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 1023);
        queue_word(KIND_WRITE, NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 1023);
        queue_word(KIND_TEST, NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 0);
        queue_word(KIND_WRITE, NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 0);
        queue_word(KIND_TEST, NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 1023);
        queue_word(KIND_WRITE, NUM_ROWS - 3, NUM_LAYERS - 3, NUM_COLS - 3, 0);
        queue_word(KIND_TEST, NUM_ROWS - 2, NUM_LAYERS - 2, NUM_COLS - 2, 0);
        queue_word(KIND_WRITE, 0, 0, 0, 1023);
        queue_word(KIND_TEST, 0, 0, 0, 0);
        queue_word(KIND_WRITE, NUM_ROWS - 1, NUM_LAYERS - 1, NUM_COLS - 1, 0);
        queue_word(KIND_TEST, NUM_ROWS - 1, NUM_LAYERS - 1, NUM_COLS - 1, 1023);

        drain_next = 1'b1;
        while (pending_words.size() < TOTAL_WORDS)
        begin
            idle_on = ($urandom_range(0, 2) != 0) &&
                      (pending_words.size() < TOTAL_WORDS - CALM_WORDS);
            if ($urandom_range(0, 11) == 0 &&
                pending_words.size() < TOTAL_WORDS - CALM_WORDS)
                drain_next = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                build_cube($urandom_range(1, NUM_ROWS - 2), $urandom_range(1, NUM_LAYERS - 2),
                           $urandom_range(1, NUM_COLS - 2), $urandom_range(0, 5));
            else if (pick < 8)
            begin
                repeat ($urandom_range(1, 4))
                    queue_word(KIND_WRITE, $urandom_range(0, NUM_ROWS - 1),
                               $urandom_range(0, NUM_LAYERS - 1),
                               $urandom_range(0, NUM_COLS - 1), $urandom_range(0, 1023));
            end
            else
                test_random_spot();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (!stalled && !(pending_words.size() == 0 && !staged && !start &&
                             results_seen == words_accepted))
            @(negedge clk);
        if (!stalled)
            repeat (TAIL_CYCLES) @(negedge clk);
        if (!stalled && mismatches == 0 && results_seen == words_accepted)
            $display("voxel_local_extremum_3d test passed");
        else
            $display("voxel_local_extremum_3d test failed");
        $finish;
    end

endmodule
